// ===== rtl/dltq_pkg.sv =====
// ----------------------------------------------------------------------------
// Delta list timer queue package
// Shared widths, codes, the slot word layout and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dltq_pkg;

  // Default number of list slots.
  localparam int TIMER_SLOTS_DEF = 8;

  // Field widths.
  localparam int MODE_W  = 2;
  localparam int ID_W    = 3;
  localparam int NUM_IDS = 2 ** ID_W;
  localparam int DUR_W   = 16;
  localparam int DELTA_W = 32;
  // Working width of the shared adder: wide enough for a duration plus a
  // carried overshoot, minus any stored delta, without wrapping.
  localparam int VAL_W   = 35;

  // Item kinds carried on the input tuser.
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ARM  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POLL = 2'd2;

  // Saturation limits of a stored delta, at the working width.
  localparam logic signed [VAL_W-1:0] DELTA_MAX =
    {{(VAL_W-DELTA_W+1){1'b0}}, {(DELTA_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] DELTA_MIN =
    {{(VAL_W-DELTA_W+1){1'b1}}, {(DELTA_W-1){1'b0}}};

  // One list slot as held in the slot memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELTA_W-1:0] delta;
  } slot_t;

  // Operation request to the shared adder.
  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic                    sub;
  } alu_req_t;

  // Sign-extend a stored delta to the working width.
  function automatic logic signed [VAL_W-1:0] sext_delta(input logic [DELTA_W-1:0] d);
    return {{(VAL_W-DELTA_W){d[DELTA_W-1]}}, d};
  endfunction

  // Clamp a working value to the signed delta range.
  function automatic logic [DELTA_W-1:0] sat_delta(input logic signed [VAL_W-1:0] v);
    logic [DELTA_W-1:0] r;
    if (v > DELTA_MAX) begin
      r = DELTA_MAX[DELTA_W-1:0];
    end else if (v < DELTA_MIN) begin
      r = DELTA_MIN[DELTA_W-1:0];
    end else begin
      r = v[DELTA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dltq_alu.sv =====
// ----------------------------------------------------------------------------
// Delta list timer queue shared adder
// One add or subtract at the working width, with a saturated delta copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dltq_alu (
  input  var dltq_pkg::alu_req_t                req,
  output logic signed [dltq_pkg::VAL_W-1:0]     sum,
  output logic        [dltq_pkg::DELTA_W-1:0]   sat
);

  // Add or subtract, then clamp to the stored delta range.
  always_comb begin
    if (req.sub) begin
      sum = req.a - req.b;
    end else begin
      sum = req.a + req.b;
    end
    sat = dltq_pkg::sat_delta(sum);
  end

endmodule

`default_nettype wire

// ===== rtl/delta_list_timer_queue.sv =====
// ----------------------------------------------------------------------------
// Delta list timer queue
// Sorted delta list of software timers with tick, arm and poll items.
// ----------------------------------------------------------------------------
// Each input word is worked on alone by a small sequencer around one shared
// 35-bit adder and a single-port-read slot memory with registered read data;
// read data is registered before the next state uses it. A tick lowers the
// head delta, and an arm works through the slots that it searches, moves,
// walks or shifts in turn; every word ends with a head check and a finish
// state. A result that the receiver has not yet taken holds the sequencer in
// its finish state. The input is ready only while no word is in work; a
// finished result waits in the output register without blocking the next
// input word. Reset needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module delta_list_timer_queue #(
  parameter int TIMER_SLOTS = dltq_pkg::TIMER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [2:0] timer_id, [18:3] duration_ms, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] expired, [1] rejected, rest zero
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TIMER_SLOTS);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  localparam int VAL_W   = dltq_pkg::VAL_W;
  localparam int DELTA_W = dltq_pkg::DELTA_W;
  localparam int ID_W    = dltq_pkg::ID_W;

  // Sequencer states.
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_TK_RD  = 5'd1;
  localparam logic [4:0] ST_TK_WR  = 5'd2;
  localparam logic [4:0] ST_SR_RD  = 5'd3;
  localparam logic [4:0] ST_SR_EX  = 5'd4;
  localparam logic [4:0] ST_RM_RD  = 5'd5;
  localparam logic [4:0] ST_RM_WR  = 5'd6;
  localparam logic [4:0] ST_IN_RD  = 5'd7;
  localparam logic [4:0] ST_IN_CMP = 5'd8;
  localparam logic [4:0] ST_IN_FIX = 5'd9;
  localparam logic [4:0] ST_SH_RD  = 5'd10;
  localparam logic [4:0] ST_SH_WR  = 5'd11;
  localparam logic [4:0] ST_SH_HLD = 5'd12;
  localparam logic [4:0] ST_PLACE  = 5'd13;
  localparam logic [4:0] ST_CHK_RD = 5'd14;
  localparam logic [4:0] ST_CHK_EX = 5'd15;
  localparam logic [4:0] ST_FIN    = 5'd16;

  logic [4:0]                  state;
  logic [CNT_W-1:0]            count;
  logic [dltq_pkg::NUM_IDS-1:0] expired_flags;
  logic [dltq_pkg::NUM_IDS-1:0] armed_once;

  // Work registers of the word in progress.
  logic [ID_W-1:0]             op_id;
  logic signed [VAL_W-1:0]     val;
  logic [CNT_W-1:0]            ptr;
  logic [CNT_W-1:0]            pos;
  logic [CNT_W-1:0]            rm_pos;
  logic [DELTA_W-1:0]          rm_delta;
  dltq_pkg::slot_t             held;
  logic                        exp_res;
  logic                        rej_res;

  // Slot memory.
  dltq_pkg::slot_t             mem [TIMER_SLOTS];
  dltq_pkg::slot_t             rd_q;
  logic [IDX_W-1:0]            rd_addr;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  dltq_pkg::slot_t             wr_data;

  // Shared adder.
  dltq_pkg::alu_req_t          alu_req;
  logic signed [VAL_W-1:0]     alu_sum;
  logic [DELTA_W-1:0]          alu_sat;

  logic                        in_fire;
  logic                        out_free;
  logic                        rd_nonpos;
  logic [CNT_W-1:0]            ptr_dec;
  logic [CNT_W-1:0]            pos_inc;

  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign rd_nonpos = rd_q.delta[DELTA_W-1] || (rd_q.delta == '0);
  assign ptr_dec   = ptr - ONE_C;
  assign pos_inc   = pos + ONE_C;

  dltq_alu u_alu (
    .req (alu_req),
    .sum (alu_sum),
    .sat (alu_sat)
  );

  // Operand selection for the shared adder.
  always_comb begin
    alu_req.a   = val;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    case (state)
      ST_TK_WR: begin
        alu_req.a   = dltq_pkg::sext_delta(rd_q.delta);
        alu_req.b   = VAL_W'(1);
        alu_req.sub = 1'b1;
      end
      ST_SR_EX: begin
        alu_req.b = dltq_pkg::sext_delta(rd_q.delta);
      end
      ST_RM_WR: begin
        alu_req.a = dltq_pkg::sext_delta(rd_q.delta);
        alu_req.b = dltq_pkg::sext_delta(rm_delta);
      end
      ST_IN_CMP: begin
        alu_req.b   = dltq_pkg::sext_delta(rd_q.delta);
        alu_req.sub = 1'b1;
      end
      ST_IN_FIX: begin
        alu_req.a   = dltq_pkg::sext_delta(held.delta);
        alu_req.b   = val;
        alu_req.sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Memory address and write data for each state.
  always_comb begin
    rd_addr = ptr[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr[IDX_W-1:0];
    wr_data = rd_q;
    case (state)
      ST_TK_RD, ST_CHK_RD: begin
        rd_addr = '0;
      end
      ST_TK_WR: begin
        wr_en         = 1'b1;
        wr_addr       = '0;
        wr_data.delta = alu_sat;
      end
      ST_RM_WR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_dec[IDX_W-1:0];
        if (ptr == rm_pos + ONE_C) begin
          wr_data.delta = alu_sat;
        end
      end
      ST_SH_RD: begin
        rd_addr = ptr_dec[IDX_W-1:0];
      end
      ST_SH_WR: begin
        wr_en = 1'b1;
      end
      ST_SH_HLD: begin
        wr_en   = 1'b1;
        wr_addr = pos_inc[IDX_W-1:0];
        wr_data = held;
      end
      ST_PLACE: begin
        wr_en         = 1'b1;
        wr_data.id    = op_id;
        wr_data.delta = dltq_pkg::sat_delta(val);
      end
      default: begin
      end
    endcase
  end

  // Slot memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Sequencer and list bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      expired_flags <= '0;
      armed_once    <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // A taken result drops, unless the finish state puts a new one out.
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            op_id   <= s_tdata[2:0];
            val     <= VAL_W'(s_tdata[18:3]);
            ptr     <= '0;
            exp_res <= 1'b0;
            rej_res <= 1'b0;
            case (s_tuser)
              dltq_pkg::MODE_TICK: begin
                state <= (count != '0) ? ST_TK_RD : ST_CHK_RD;
              end
              dltq_pkg::MODE_ARM: begin
                if (armed_once[s_tdata[2:0]] && (count != '0)) begin
                  state <= ST_SR_RD;
                end else if (count == SLOTS_C) begin
                  rej_res <= 1'b1;
                  state   <= ST_CHK_RD;
                end else begin
                  state <= ST_IN_RD;
                end
              end
              dltq_pkg::MODE_POLL: begin
                exp_res                     <= expired_flags[s_tdata[2:0]];
                expired_flags[s_tdata[2:0]] <= 1'b0;
                state                       <= ST_CHK_RD;
              end
              default: begin
                state <= ST_CHK_RD;
              end
            endcase
          end
        end
        // Tick: lower the head delta by one.
        ST_TK_RD: begin
          state <= ST_TK_WR;
        end
        ST_TK_WR: begin
          state <= ST_CHK_RD;
        end
        // Re-arm: look for the slot that holds this id.
        ST_SR_RD: begin
          state <= ST_SR_EX;
        end
        ST_SR_EX: begin
          if (rd_q.id == op_id) begin
            rm_pos   <= ptr;
            rm_delta <= rd_q.delta;
            if ((ptr == '0) && rd_nonpos) begin
              val <= alu_sum;
            end
            ptr   <= ptr + ONE_C;
            state <= ST_RM_RD;
          end else if (ptr + ONE_C == count) begin
            if (count == SLOTS_C) begin
              rej_res <= 1'b1;
              state   <= ST_CHK_RD;
            end else begin
              ptr   <= '0;
              state <= ST_IN_RD;
            end
          end else begin
            ptr   <= ptr + ONE_C;
            state <= ST_SR_RD;
          end
        end
        // Remove: move later slots down, merging the removed delta.
        ST_RM_RD: begin
          if (ptr >= count) begin
            count <= count - ONE_C;
            ptr   <= '0;
            state <= ST_IN_RD;
          end else begin
            state <= ST_RM_WR;
          end
        end
        ST_RM_WR: begin
          ptr   <= ptr + ONE_C;
          state <= ST_RM_RD;
        end
        // Insert: walk the list, taking off each delta that fits.
        ST_IN_RD: begin
          state <= (ptr == count) ? ST_PLACE : ST_IN_CMP;
        end
        ST_IN_CMP: begin
          if (!alu_sum[VAL_W-1]) begin
            val   <= alu_sum;
            ptr   <= ptr + ONE_C;
            state <= ST_IN_RD;
          end else begin
            held  <= rd_q;
            val   <= dltq_pkg::sext_delta(dltq_pkg::sat_delta(val));
            state <= ST_IN_FIX;
          end
        end
        ST_IN_FIX: begin
          held.delta <= alu_sat;
          pos        <= ptr;
          ptr        <= count;
          state      <= ST_SH_RD;
        end
        // Open a gap at the insert position, from the tail down.
        ST_SH_RD: begin
          state <= (ptr == pos_inc) ? ST_SH_HLD : ST_SH_WR;
        end
        ST_SH_WR: begin
          ptr   <= ptr_dec;
          state <= ST_SH_RD;
        end
        ST_SH_HLD: begin
          ptr   <= pos;
          state <= ST_PLACE;
        end
        ST_PLACE: begin
          count             <= count + ONE_C;
          armed_once[op_id] <= 1'b1;
          state             <= ST_CHK_RD;
        end
        // Head check that follows every word.
        ST_CHK_RD: begin
          state <= (count != '0) ? ST_CHK_EX : ST_FIN;
        end
        ST_CHK_EX: begin
          if (rd_nonpos) begin
            expired_flags[rd_q.id] <= 1'b1;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, rej_res, exp_res};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The list never holds more slots than it has.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= SLOTS_C)
    else $error("slot count above capacity");

  // A new result appears only when a word finishes.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FIN)
    else $error("result raised outside finish");

  // A placed slot grows the list by exactly one.
  a_place_grow: assert property (@(posedge clk) disable iff (rst)
    state == ST_PLACE |=> count == $past(count) + ONE_C)
    else $error("insert did not grow the list");

  // A rejected arm is reported only with a full list.
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) && rej_res |-> count == SLOTS_C)
    else $error("arm rejected with free slots");

endmodule

`default_nettype wire

// ===== dv/tb_delta_list_timer_queue.sv =====
// ----------------------------------------------------------------------------
// Delta list timer queue testbench
// Drives tick, arm, poll and no-op words into the timer queue and checks each
// answer word against an internal model of the sorted delta list. A directed
// opening covers the corner cases. Random phases then run with no idling,
// with an idle sender, with a stalling receiver (including one long hold-off),
// and with both sides idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_delta_list_timer_queue;

  localparam int CLK_PERIOD = 8;
  localparam int SLOTS      = dltq_pkg::TIMER_SLOTS_DEF;
  localparam int MODE_W     = dltq_pkg::MODE_W;
  localparam int ID_W       = dltq_pkg::ID_W;
  localparam int DUR_W      = dltq_pkg::DUR_W;
  localparam int NUM_IDS    = dltq_pkg::NUM_IDS;
  localparam int DRAIN_WAIT = 8 * SLOTS + 40;
  localparam int HOLD_LEN   = 500;
  localparam longint LIMIT_NS = 64'd10_000_000;

  // The one kind that the package does not name: it does nothing.
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic [DUR_W-1:0]  dur;
  } timer_word_t;

  typedef struct {
    logic expired;
    logic rejected;
  } timer_answer_t;

  // DUT connections; the driven ones are known from time zero.
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // [2:0] timer_id, [18:3] duration_ms, rest zero
  logic [1:0]  s_tuser  = '0;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [0] expired, [1] rejected, rest zero

  // Model of the timer list.
  logic [ID_W-1:0] lst_id    [SLOTS];
  int              lst_delta [SLOTS];
  int              lst_count;
  bit              fired      [NUM_IDS];
  bit              ever_armed [NUM_IDS];

  timer_word_t   pend_words[$];
  timer_answer_t timer_answers[$];
  timer_word_t   cur_word;
  timer_answer_t got_answer;

  int  snd_idle_pct  = 0;
  int  rcv_stall_pct = 0;
  bit  hold_go       = 1'b0;
  bit  rx_hold       = 1'b0;
  int  err_cnt       = 0;
  int  checked_cnt   = 0;
  int  expired_seen  = 0;
  int  kind_cnt [4]  = '{0, 0, 0, 0};

  delta_list_timer_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Clamp to the 32-bit signed range of a stored delta.
  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  // Update the timer list for one accepted word and queue its answer.
  function automatic void step_timer_list(timer_word_t w);
    timer_answer_t ans;
    longint        val;
    int            p;
    int            pos;
    int            d;
    bit            found;
    ans   = '{expired: 1'b0, rejected: 1'b0};
    found = 1'b0;
    p     = 0;
    case (w.mode)
      dltq_pkg::MODE_TICK: begin
        if (lst_count > 0) begin
          lst_delta[0] = clamp32(longint'(lst_delta[0]) - 1);
        end
      end
      dltq_pkg::MODE_ARM: begin
        val = longint'(w.dur);
        // A re-arm pulls the old entry out and hands its delta to the next one.
        if (ever_armed[w.id]) begin
          while (p < lst_count && lst_id[p] != w.id) p++;
          found = (p < lst_count);
        end
        if (found) begin
          d = lst_delta[p];
          if (p == 0 && d <= 0) begin
            val += d;
          end
          if (p + 1 < lst_count) begin
            lst_delta[p+1] = clamp32(longint'(lst_delta[p+1]) + d);
          end
          for (int i = p + 1; i < lst_count; i++) begin
            lst_id[i-1]    = lst_id[i];
            lst_delta[i-1] = lst_delta[i];
          end
          lst_count--;
        end
        if (!found && lst_count >= SLOTS) begin
          ans.rejected = 1'b1;
        end else begin
          // Walk the list, consuming deltas, then open a slot at the stop.
          pos = 0;
          while (pos < lst_count && val >= longint'(lst_delta[pos])) begin
            val -= lst_delta[pos];
            pos++;
          end
          val = clamp32(val);
          if (pos < lst_count) begin
            lst_delta[pos] = clamp32(longint'(lst_delta[pos]) - val);
          end
          for (int i = lst_count; i > pos; i--) begin
            lst_id[i]    = lst_id[i-1];
            lst_delta[i] = lst_delta[i-1];
          end
          lst_id[pos]    = w.id;
          lst_delta[pos] = int'(val);
          lst_count++;
          ever_armed[w.id] = 1'b1;
        end
      end
      dltq_pkg::MODE_POLL: begin
        ans.expired = fired[w.id];
        fired[w.id] = 1'b0;
      end
      default: begin
      end
    endcase
    // A head at or below zero marks its timer as expired after every word.
    if (lst_count > 0 && lst_delta[0] <= 0) begin
      fired[lst_id[0]] = 1'b1;
    end
    timer_answers.push_back(ans);
  endfunction

  function automatic void queue_word(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                     logic [DUR_W-1:0] dur);
    timer_word_t w;
    w.mode = mode;
    w.id   = id;
    w.dur  = dur;
    pend_words.push_back(w);
  endfunction

  // Random word: mostly ticks and short arms so timers actually expire.
  function automatic void queue_random_word();
    int          pick;
    int          dpick;
    logic [DUR_W-1:0] dur;
    pick  = $urandom_range(99);
    dpick = $urandom_range(99);
    if (dpick < 70) begin
      dur = DUR_W'($urandom_range(15));
    end else if (dpick < 90) begin
      dur = DUR_W'($urandom_range(300));
    end else if (dpick < 95) begin
      dur = '1;
    end else begin
      dur = DUR_W'($urandom);
    end
    if (pick < 45) begin
      queue_word(dltq_pkg::MODE_TICK, ID_W'($urandom), DUR_W'($urandom));
    end else if (pick < 75) begin
      queue_word(dltq_pkg::MODE_ARM, ID_W'($urandom), dur);
    end else if (pick < 97) begin
      queue_word(dltq_pkg::MODE_POLL, ID_W'($urandom), DUR_W'($urandom));
    end else begin
      queue_word(MODE_NOP, ID_W'($urandom), DUR_W'($urandom));
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Wait until every queued word went in and every answer came back.
  task automatic drain_all();
    do @(negedge clk);
    while (pend_words.size() != 0 || s_tvalid || timer_answers.size() != 0);
  endtask

  task automatic run_random(int n);
    repeat (n) queue_random_word();
    drain_all();
  endtask

  // Input driver: models each accepted word, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        step_timer_list(cur_word);
        kind_cnt[cur_word.mode]++;
      end
      if (!s_tvalid || s_tready) begin
        if (pend_words.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          cur_word = pend_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {5'b0, cur_word.dur, cur_word.id};
          s_tuser  <= cur_word.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_hold && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // One long receiver hold-off while the sender keeps offering words.
  initial begin
    wait (hold_go);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_LEN) @(negedge clk);
    rx_hold = 1'b0;
  end

  // Output monitor: compares each answer word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (timer_answers.size() == 0) begin
        report_mismatch($sformatf("answer word 0x%02h with none pending", m_tdata));
      end else begin
        got_answer = timer_answers.pop_front();
        if (m_tdata[0] !== got_answer.expired) begin
          report_mismatch($sformatf("answer %0d: expired %b, predicted %b",
                                    checked_cnt, m_tdata[0], got_answer.expired));
        end
        if (m_tdata[1] !== got_answer.rejected) begin
          report_mismatch($sformatf("answer %0d: rejected %b, predicted %b",
                                    checked_cnt, m_tdata[1], got_answer.rejected));
        end
        if (m_tdata[7:2] !== '0) begin
          report_mismatch($sformatf("answer %0d: pad bits 0x%02h not zero",
                                    checked_cnt, m_tdata[7:2]));
        end
        if (got_answer.expired) begin
          expired_seen++;
        end
        checked_cnt++;
      end
    end
  end

  // Watchdog.
  initial begin
    #(LIMIT_NS);
    $display("Timeout with %0d answers outstanding", timer_answers.size());
    $display("delta_list_timer_queue verification failed");
    $finish;
  end

  // Main sequence.
  initial begin
    lst_count = 0;
    for (int i = 0; i < NUM_IDS; i++) begin
      fired[i]      = 1'b0;
      ever_armed[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening: empty list, unknown kind, expiry at once, overshoot carry.
    queue_word(dltq_pkg::MODE_TICK, 3'd0, 16'h0000);   // tick with nothing armed
    queue_word(dltq_pkg::MODE_POLL, 3'd5, 16'hffff);   // poll of a never-armed timer
    queue_word(MODE_NOP,            3'd7, 16'hffff);   // unknown kind, all ones
    queue_word(dltq_pkg::MODE_ARM,  3'd0, 16'h0000);   // zero duration expires at once
    queue_word(dltq_pkg::MODE_POLL, 3'd0, 16'h0000);   // flag set, and set again after
    queue_word(dltq_pkg::MODE_POLL, 3'd0, 16'h0000);
    queue_word(dltq_pkg::MODE_ARM,  3'd0, 16'h0003);   // re-arm of an expired head
    repeat (4) queue_word(dltq_pkg::MODE_TICK, 3'd0, 16'h0000);   // one past expiry
    queue_word(dltq_pkg::MODE_ARM,  3'd0, 16'h0005);   // overshoot carried into delay
    queue_word(dltq_pkg::MODE_ARM,  3'd1, 16'hffff);
    queue_word(dltq_pkg::MODE_ARM,  3'd2, 16'h0002);
    queue_word(dltq_pkg::MODE_ARM,  3'd3, 16'h0064);
    queue_word(dltq_pkg::MODE_ARM,  3'd4, 16'h0001);
    queue_word(dltq_pkg::MODE_ARM,  3'd5, 16'hffff);
    queue_word(dltq_pkg::MODE_ARM,  3'd6, 16'h0007);
    queue_word(dltq_pkg::MODE_ARM,  3'd7, 16'h8000);   // list now full
    queue_word(dltq_pkg::MODE_ARM,  3'd3, 16'h0032);   // re-arm of an entry in the middle
    queue_word(dltq_pkg::MODE_ARM,  3'd1, 16'h0000);   // re-arm of the next-to-last entry to the front
    queue_word(dltq_pkg::MODE_TICK, 3'd7, 16'hffff);
    queue_word(dltq_pkg::MODE_POLL, 3'd1, 16'h0000);
    queue_word(dltq_pkg::MODE_POLL, 3'd7, 16'hffff);
    drain_all();

    // Random phases under different idling patterns.
    run_random(220);
    snd_idle_pct = 78;
    run_random(200);
    snd_idle_pct  = 0;
    rcv_stall_pct = 78;
    hold_go       = 1'b1;
    run_random(200);
    snd_idle_pct  = 23;
    rcv_stall_pct = 23;
    run_random(200);

    // Let any stray answer show up before the verdict.
    repeat (DRAIN_WAIT) @(posedge clk);
    if (timer_answers.size() != 0) begin
      report_mismatch($sformatf("%0d answers never arrived", timer_answers.size()));
    end

    $display("Covered %0d ticks, %0d arms, %0d polls and %0d no-op words,",
             kind_cnt[dltq_pkg::MODE_TICK], kind_cnt[dltq_pkg::MODE_ARM],
             kind_cnt[dltq_pkg::MODE_POLL], kind_cnt[MODE_NOP]);
    $display("with %0d answers checked (%0d expired polls) under four idling patterns.",
             checked_cnt, expired_seen);
    if (err_cnt == 0) begin
      $display("delta_list_timer_queue verification clean");
    end else begin
      $display("delta_list_timer_queue verification failed");
    end
    $finish;
  end

endmodule
